// File: rtl/core/bsap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery sample average package
// Shared widths, register codes, reset values, curve table and the
// controller/datapath command and status types.
// ----------------------------------------------------------------------------
package bsap_pkg;

  localparam int unsigned ADC_CODE_W   = 14;
  localparam int unsigned MV_W         = 16;
  localparam int unsigned GAIN_W       = 18;
  localparam int unsigned SUM_W        = 24;
  localparam int unsigned PCT_W        = 7;
  localparam int unsigned COUNT_OUT_W  = 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 18;

  localparam int unsigned DIVD_W       = SUM_W + 1;
  localparam int unsigned DIV_CNT_W    = $clog2(DIVD_W);

  localparam int unsigned SLOPE_PROD_W = 32;
  localparam int unsigned SLOPE_SHIFT  = 5;
  localparam int unsigned SCAN_W       = SLOPE_PROD_W + SLOPE_SHIFT;
  localparam int unsigned CURVE_SCALE  = 125;

  localparam int unsigned CURVE_N      = 50;
  localparam int unsigned CURVE_W      = 19;
  localparam int unsigned CURVE_IDX_W  = $clog2(CURVE_N);
  localparam int unsigned HITS_W       = $clog2(CURVE_N + 1);

  localparam logic [PCT_W-1:0] PCT_MID  = 7'd50;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [GAIN_W-1:0] RST_MV_PER_CODE = 18'd7201;
  localparam logic [MV_W-1:0]   RST_ABSENT_THR  = 16'd4500;
  localparam logic [MV_W-1:0]   RST_VALID_MIN   = 16'd2500;
  localparam logic [MV_W-1:0]   RST_VALID_MAX   = 16'd4300;
  localparam logic [MV_W-1:0]   RST_FIT_SLOPE   = 16'd2560;
  localparam logic [MV_W-1:0]   RST_FIT_MID     = 16'd3700;

  // Q16 logistic arguments at which the rounded percent steps up by one.
  localparam logic [CURVE_W-1:0] CURVE_Q16 [CURVE_N] = '{
    19'd1311,   19'd3933,   19'd6559,   19'd9190,   19'd11828,
    19'd14477,  19'd17136,  19'd19810,  19'd22501,  19'd25210,
    19'd27941,  19'd30696,  19'd33477,  19'd36289,  19'd39134,
    19'd42015,  19'd44935,  19'd47899,  19'd50911,  19'd53975,
    19'd57096,  19'd60280,  19'd63531,  19'd66856,  19'd70262,
    19'd73758,  19'd77351,  19'd81052,  19'd84872,  19'd88823,
    19'd92920,  19'd97179,  19'd101620, 19'd106266, 19'd111143,
    19'd116285, 19'd121730, 19'd127527, 19'd133736, 19'd140435,
    19'd147722, 19'd155731, 19'd164646, 19'd174729, 19'd186375,
    19'd200216, 19'd217368, 19'd240095, 19'd274241, 19'd346902
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MV_PER_CODE = 3'd0,
    REG_ABSENT_THR  = 3'd1,
    REG_VALID_MIN   = 3'd2,
    REG_VALID_MAX   = 3'd3,
    REG_FIT_SLOPE   = 3'd4,
    REG_FIT_MID     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [GAIN_W-1:0] mv_per_code_q16;
    logic [MV_W-1:0]   absent_threshold_mv;
    logic [MV_W-1:0]   valid_min_mv;
    logic [MV_W-1:0]   valid_max_mv;
    logic [MV_W-1:0]   fit_slope_q8;
    logic [MV_W-1:0]   fit_mid_mv;
  } cfg_t;

  typedef struct packed {
    logic [ADC_CODE_W-1:0] adc_code;
    logic                  last_sample;
  } in_item_t;

  typedef struct packed {
    logic [MV_W-1:0]        voltage_mv;
    logic                   battery_absent;
    logic                   no_valid_samples;
    logic [PCT_W-1:0]       charge_percent;
    logic [COUNT_OUT_W-1:0] valid_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_DIV_LOAD,
    ST_DIV,
    ST_DIFF,
    ST_MUL,
    ST_SCAN,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic div_load;
    logic div_step;
    logic diff;
    logic mul;
    logic scan_step;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last;
    logic div_done;
    logic scan_done;
  } ctrl_status_t;

endpackage
`default_nettype wire

// File: rtl/core/bsap_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery sample average stream interface
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
interface bsap_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/bsap_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery sample average configuration registers
// Write-only register bank; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module bsap_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [bsap_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bsap_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output bsap_pkg::cfg_t                        cfg_o
);

  bsap_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bsap_pkg::cfg_reg_e'(cfg_idx_i))
        bsap_pkg::REG_MV_PER_CODE: cfg_d.mv_per_code_q16     = cfg_wdata_i;
        bsap_pkg::REG_ABSENT_THR:  cfg_d.absent_threshold_mv = cfg_wdata_i[15:0];
        bsap_pkg::REG_VALID_MIN:   cfg_d.valid_min_mv        = cfg_wdata_i[15:0];
        bsap_pkg::REG_VALID_MAX:   cfg_d.valid_max_mv        = cfg_wdata_i[15:0];
        bsap_pkg::REG_FIT_SLOPE:   cfg_d.fit_slope_q8        = cfg_wdata_i[15:0];
        bsap_pkg::REG_FIT_MID:     cfg_d.fit_mid_mv          = cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mv_per_code_q16     <= bsap_pkg::RST_MV_PER_CODE;
      cfg_q.absent_threshold_mv <= bsap_pkg::RST_ABSENT_THR;
      cfg_q.valid_min_mv        <= bsap_pkg::RST_VALID_MIN;
      cfg_q.valid_max_mv        <= bsap_pkg::RST_VALID_MAX;
      cfg_q.fit_slope_q8        <= bsap_pkg::RST_FIT_SLOPE;
      cfg_q.fit_mid_mv          <= bsap_pkg::RST_FIT_MID;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

// File: rtl/core/bsap_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery sample average controller
// Sequences sample capture, accumulation, the end-of-run divide, the
// curve scan and the result register.
// ----------------------------------------------------------------------------
module bsap_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  input  wire logic            out_ready_i,
  input  bsap_pkg::ctrl_status_t status_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  output bsap_pkg::ctrl_cmd_t  cmd_o
);

  bsap_pkg::ctrl_state_e state_q, state_d;
  logic                  out_valid_q, out_valid_d;
  logic                  out_free;

  assign in_ready_o = (state_q == bsap_pkg::ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      bsap_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = bsap_pkg::ST_ACC;
        end
      end
      bsap_pkg::ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        state_d = status_i.last ? bsap_pkg::ST_DIV_LOAD : bsap_pkg::ST_IDLE;
      end
      bsap_pkg::ST_DIV_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = bsap_pkg::ST_DIV;
      end
      bsap_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_done) begin
          state_d = bsap_pkg::ST_DIFF;
        end
      end
      bsap_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = bsap_pkg::ST_MUL;
      end
      bsap_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = bsap_pkg::ST_SCAN;
      end
      bsap_pkg::ST_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.scan_done) begin
          state_d = bsap_pkg::ST_DONE;
        end
      end
      bsap_pkg::ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = bsap_pkg::ST_IDLE;
        end
      end
      default: state_d = bsap_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.load_out || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bsap_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTH
  a_load_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("Result loaded while the previous one was still pending.");

  a_capture_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == bsap_pkg::ST_ACC))
    else $error("Captured sample was not accumulated next cycle.");
`endif

endmodule
`default_nettype wire

// File: rtl/core/bsap_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery sample average datapath
// Code scaling, run accumulation, bit-serial mean divider, logistic
// curve scan and the result register.
// ----------------------------------------------------------------------------
module bsap_datapath #(
  parameter int unsigned MAX_SAMPLES = 255,
  parameter int unsigned ADC_BITS    = 14
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  bsap_pkg::cfg_t                         cfg_i,
  input  bsap_pkg::ctrl_cmd_t                    cmd_i,
  input  wire logic [bsap_pkg::ADC_CODE_W-1:0]   code_i,
  input  wire logic                              last_i,
  output bsap_pkg::ctrl_status_t                 status_o,
  output bsap_pkg::out_item_t                    out_o
);

  localparam int unsigned USED_W = (ADC_BITS < bsap_pkg::ADC_CODE_W) ?
                                   ADC_BITS : bsap_pkg::ADC_CODE_W;
  localparam int unsigned PROD_W = USED_W + bsap_pkg::GAIN_W;
  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned WIDE_W = 40;

  logic [PROD_W-1:0]                  prod_q;
  logic                               last_q;
  logic [bsap_pkg::SUM_W-1:0]         sum_q;
  logic [CNT_W-1:0]                   valid_tally_q;
  logic [CNT_W-1:0]                   absent_tally_q;
  logic [CNT_W-1:0]                   run_tally_q;
  logic [bsap_pkg::DIVD_W-1:0]        divd_q;
  logic [CNT_W-1:0]                   rem_q;
  logic [bsap_pkg::DIV_CNT_W-1:0]     div_cnt_q;
  logic                               absent_q;
  logic                               above_q;
  logic [bsap_pkg::MV_W-1:0]          volt_q;
  logic [bsap_pkg::MV_W-1:0]          diff_q;
  logic [bsap_pkg::SLOPE_PROD_W-1:0]  slope_prod_q;
  logic [bsap_pkg::CURVE_IDX_W-1:0]   scan_idx_q;
  logic [bsap_pkg::HITS_W-1:0]        hits_q;
  bsap_pkg::out_item_t                out_q;

  logic [WIDE_W-1:0]                  rounded;
  logic [23:0]                        mv_wide;
  logic [bsap_pkg::MV_W-1:0]          mv;
  logic                               counted;
  logic                               is_absent;
  logic                               in_window;
  logic [CNT_W:0]                     trial;
  logic                               trial_ge;
  logic [bsap_pkg::MV_W-1:0]          volt_sel;
  logic [bsap_pkg::SCAN_W-1:0]        scan_arg;
  logic [bsap_pkg::SCAN_W-1:0]        scan_limit;
  logic [bsap_pkg::PCT_W-1:0]         pct;

  always_comb begin
    rounded   = WIDE_W'(prod_q) + WIDE_W'(32'd32768);
    mv_wide   = rounded[39:16];
    mv        = (mv_wide > 24'd65535) ? 16'hFFFF : mv_wide[15:0];
    counted   = run_tally_q < CNT_W'(MAX_SAMPLES);
    is_absent = mv >= cfg_i.absent_threshold_mv;
    in_window = (mv >= cfg_i.valid_min_mv) && (mv <= cfg_i.valid_max_mv);

    trial    = {rem_q, divd_q[bsap_pkg::DIVD_W-1]};
    trial_ge = trial >= {1'b0, valid_tally_q};

    volt_sel = (absent_q || (valid_tally_q == '0)) ? '0 : divd_q[bsap_pkg::MV_W-1:0];

    scan_arg   = bsap_pkg::SCAN_W'(slope_prod_q) << bsap_pkg::SLOPE_SHIFT;
    scan_limit = bsap_pkg::SCAN_W'(bsap_pkg::CURVE_Q16[scan_idx_q]) *
                 bsap_pkg::SCAN_W'(bsap_pkg::CURVE_SCALE);

    if (absent_q) begin
      pct = bsap_pkg::PCT_FULL;
    end else if (above_q) begin
      pct = bsap_pkg::PCT_MID + bsap_pkg::PCT_W'(hits_q);
    end else begin
      pct = bsap_pkg::PCT_MID - bsap_pkg::PCT_W'(hits_q);
    end
  end

  // Run state and sequencing counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q          <= '0;
      valid_tally_q  <= '0;
      absent_tally_q <= '0;
      run_tally_q    <= '0;
      div_cnt_q      <= '0;
      scan_idx_q     <= '0;
      hits_q         <= '0;
    end else begin
      if (cmd_i.accumulate && counted) begin
        run_tally_q <= run_tally_q + 1'b1;
        if (is_absent) begin
          absent_tally_q <= absent_tally_q + 1'b1;
        end else if (in_window) begin
          sum_q         <= sum_q + bsap_pkg::SUM_W'(mv);
          valid_tally_q <= valid_tally_q + 1'b1;
        end
      end
      if (cmd_i.div_load) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (cmd_i.mul) begin
        scan_idx_q <= '0;
        hits_q     <= '0;
      end else if (cmd_i.scan_step) begin
        scan_idx_q <= scan_idx_q + 1'b1;
        if (scan_arg >= scan_limit) begin
          hits_q <= hits_q + 1'b1;
        end
      end
      if (cmd_i.load_out) begin
        sum_q          <= '0;
        valid_tally_q  <= '0;
        absent_tally_q <= '0;
        run_tally_q    <= '0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      prod_q <= PROD_W'(code_i[USED_W-1:0]) * PROD_W'(cfg_i.mv_per_code_q16);
      last_q <= last_i;
    end
    if (cmd_i.div_load) begin
      divd_q   <= bsap_pkg::DIVD_W'(sum_q) + bsap_pkg::DIVD_W'(valid_tally_q >> 1);
      rem_q    <= '0;
      absent_q <= (run_tally_q != '0) && (absent_tally_q == run_tally_q);
    end else if (cmd_i.div_step) begin
      divd_q <= {divd_q[bsap_pkg::DIVD_W-2:0], trial_ge};
      rem_q  <= trial_ge ? CNT_W'(trial - {1'b0, valid_tally_q}) : trial[CNT_W-1:0];
    end
    if (cmd_i.diff) begin
      volt_q  <= volt_sel;
      above_q <= volt_sel >= cfg_i.fit_mid_mv;
      diff_q  <= (volt_sel >= cfg_i.fit_mid_mv) ? volt_sel - cfg_i.fit_mid_mv :
                                                  cfg_i.fit_mid_mv - volt_sel;
    end
    if (cmd_i.mul) begin
      slope_prod_q <= bsap_pkg::SLOPE_PROD_W'(cfg_i.fit_slope_q8) *
                      bsap_pkg::SLOPE_PROD_W'(diff_q);
    end
    if (cmd_i.load_out) begin
      out_q.voltage_mv       <= volt_q;
      out_q.battery_absent   <= absent_q;
      out_q.no_valid_samples <= (valid_tally_q == '0);
      out_q.charge_percent   <= pct;
      out_q.valid_count      <= bsap_pkg::COUNT_OUT_W'(valid_tally_q);
    end
  end

  assign status_o.last      = last_q;
  assign status_o.div_done  = div_cnt_q == bsap_pkg::DIV_CNT_W'(bsap_pkg::DIVD_W - 1);
  assign status_o.scan_done = scan_idx_q == bsap_pkg::CURVE_IDX_W'(bsap_pkg::CURVE_N - 1);
  assign out_o              = out_q;

`ifndef SYNTH
  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_tally_q <= CNT_W'(MAX_SAMPLES))
    else $error("Run tally went past the sample limit.");

  a_tallies_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CNT_W + 1)'(valid_tally_q) + (CNT_W + 1)'(absent_tally_q)) <=
    (CNT_W + 1)'(run_tally_q))
    else $error("Valid and absent tallies exceed the run tally.");
`endif

endmodule
`default_nettype wire

// File: rtl/core/battery_sample_average_percent.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Battery sample average percent
// Averages a run of converter samples in millivolts and estimates charge.
// ----------------------------------------------------------------------------
// A sample that is not marked last passes through the transfer cycle,
// which registers the code times gain product, and the accumulate cycle,
// after which ready is high again. A sample marked last then goes through
// the accumulate, the divider load, the 25 steps of the bit-serial mean
// divider, the difference, the slope multiply, the 50 steps of the
// one-point-per-cycle curve scan and the result load, which waits until
// the output register is free. Samples are taken again once the result
// is loaded, even while it still waits for its transfer. Configuration
// writes take effect at the next clock and need no clearing pass.
// ----------------------------------------------------------------------------
module battery_sample_average_percent #(
  parameter int unsigned MAX_SAMPLES = 255,
  parameter int unsigned ADC_BITS    = 14
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  bsap_stream_if.sink                           sample_i,
  bsap_stream_if.source                         result_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [bsap_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [bsap_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  bsap_pkg::cfg_t         cfg;
  bsap_pkg::ctrl_cmd_t    cmd;
  bsap_pkg::ctrl_status_t status;
  bsap_pkg::out_item_t    out_item;
  logic                   in_ready;
  logic                   out_valid;

  bsap_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bsap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .out_ready_i (result_o.ready),
    .status_i    (status),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  bsap_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .ADC_BITS    (ADC_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .cmd_i    (cmd),
    .code_i   (sample_i.data.adc_code),
    .last_i   (sample_i.data.last_sample),
    .status_o (status),
    .out_o    (out_item)
  );

  assign sample_i.ready = in_ready;
  assign result_o.valid = out_valid;
  assign result_o.data  = out_item;

endmodule
`default_nettype wire
